FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`endif

FILE: design/eptt_pkg.sv
// Package with the shared types and constants of the epoch page tracking table.
package eptt_pkg;
  localparam int unsigned TableEntriesDef  = 1024;
  localparam int unsigned DefaultWindowDef = 64;
  localparam int unsigned PageShiftDef     = 12;
  localparam int unsigned AddrWidthDef     = 48;
  localparam int unsigned EpochWidthDef    = 32;
  localparam logic [10:0] ThresholdReset   = 11'd512;

  typedef enum logic [1:0] {
    StHit   = 2'd0,
    StFill  = 2'd1,
    StGrow  = 2'd2,
    StDrop  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    SClear, SIdle, SSwRd, SSwChk, SSwEnd, SSeRd, SSeChk, SDecide, SOut
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_en;    // write entry at index as empty
    logic idx_zero;
    logic idx_inc;
    logic load_item;
    logic rd_en;
    logic sweep_chk;   // evaluate the entry read for the sweep
    logic sweep_end;   // apply the window halving
    logic search_chk;  // evaluate the entry read for the search
    logic decide;      // write the hit, fill or grow entry, produce the result
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idx_last_clear;
    logic idx_at_span;
    logic need_sweep;
    logic found;
  } stat_t;
endpackage

FILE: design/epoch_page_tracking_table.sv
// Top level of the epoch page tracking table.
// After an item is accepted, an optional sweep reads and checks each entry of the window,
// then a search reads entries in order until a hit or the end of the window, then the
// hit or new entry, if any, is written and the result is held until taken. Throughput is one item
// at a time: no new item is accepted until the result is taken. After reset a clearing pass
// writes every entry, with no item accepted; configuration writes are taken during it.
module epoch_page_tracking_table import eptt_pkg::*; #(
  parameter int unsigned TableEntries  = TableEntriesDef,
  parameter int unsigned DefaultWindow = DefaultWindowDef,
  parameter int unsigned PageShift     = PageShiftDef,
  parameter int unsigned AddrWidth     = AddrWidthDef,
  parameter int unsigned EpochWidth    = EpochWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [AddrWidth-1:0]  byte_address_i,
  input  logic                  is_remove_i,
  input  logic [EpochWidth-1:0] current_epoch_i,
  input  logic [EpochWidth-1:0] collect_epoch_i,
  input  logic                  force_clean_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            status_o,
  output logic [9:0]            entry_index_o,
  output logic [10:0]           occupied_count_o,
  output logic [9:0]            window_size_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [10:0]           cfg_data_i
);
  ctrl_t ctrl;
  stat_t stat;

  eptt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid (in_valid_i),
    .in_stall (in_stall_o),
    .out_valid(out_valid_o),
    .out_stall(out_stall_i),
    .cfg_ready(cfg_ready_o),
    .stat_i   (stat),
    .ctrl_o   (ctrl)
  );

  eptt_dp #(
    .TableEntries(TableEntries), .DefaultWindow(DefaultWindow),
    .PageShift(PageShift), .AddrWidth(AddrWidth), .EpochWidth(EpochWidth)
  ) u_dp (
    .clk_i, .rst_ni,
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .cfg_we        (cfg_valid_i && cfg_ready_o),
    .cfg_data      (cfg_data_i),
    .byte_address  (byte_address_i),
    .is_remove     (is_remove_i),
    .current_epoch (current_epoch_i),
    .collect_epoch (collect_epoch_i),
    .force_clean   (force_clean_i),
    .status        (status_o),
    .entry_index   (entry_index_o),
    .occupied_count(occupied_count_o),
    .window_size   (window_size_o)
  );
endmodule

FILE: design/eptt_ctrl.sv
// Controller state machine of the epoch page tracking table.
module eptt_ctrl import eptt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  output logic  cfg_ready,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d   = state_q;
    ctrl_o    = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    cfg_ready = 1'b0;
    case (state_q)
      SClear: begin
        ctrl_o.clear_en = 1'b1;
        ctrl_o.idx_inc  = 1'b1;
        cfg_ready       = 1'b1;
        if (stat_i.idx_last_clear) begin
          ctrl_o.idx_inc  = 1'b0;
          ctrl_o.idx_zero = 1'b1;
          state_d         = SIdle;
        end
      end
      SIdle: begin
        in_stall  = 1'b0;
        cfg_ready = !in_valid;
        if (in_valid) begin
          ctrl_o.load_item = 1'b1;
          ctrl_o.idx_zero  = 1'b1;
          state_d          = SSwRd;
        end
      end
      SSwRd: begin
        if (!stat_i.need_sweep) begin
          state_d = SSeRd;
        end else if (stat_i.idx_at_span) begin
          state_d = SSwEnd;
        end else begin
          ctrl_o.rd_en = 1'b1;
          state_d      = SSwChk;
        end
      end
      SSwChk: begin
        ctrl_o.sweep_chk = 1'b1;
        ctrl_o.idx_inc   = 1'b1;
        state_d          = SSwRd;
      end
      SSwEnd: begin
        ctrl_o.sweep_end = 1'b1;
        ctrl_o.idx_zero  = 1'b1;
        state_d          = SSeRd;
      end
      SSeRd: begin
        if (stat_i.idx_at_span) begin
          state_d = SDecide;
        end else begin
          ctrl_o.rd_en = 1'b1;
          state_d      = SSeChk;
        end
      end
      SSeChk: begin
        ctrl_o.search_chk = 1'b1;
        if (stat_i.found) begin
          state_d = SDecide;
        end else begin
          ctrl_o.idx_inc = 1'b1;
          state_d        = SSeRd;
        end
      end
      SDecide: begin
        ctrl_o.decide = 1'b1;
        state_d       = SOut;
      end
      SOut: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end
endmodule

FILE: design/eptt_dp.sv
// Datapath of the epoch page tracking table: entry memory, counters and result.
module eptt_dp import eptt_pkg::*; #(
  parameter int unsigned TableEntries  = TableEntriesDef,
  parameter int unsigned DefaultWindow = DefaultWindowDef,
  parameter int unsigned PageShift     = PageShiftDef,
  parameter int unsigned AddrWidth     = AddrWidthDef,
  parameter int unsigned EpochWidth    = EpochWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_t                 ctrl_i,
  output stat_t                 stat_o,
  input  logic                  cfg_we,
  input  logic [10:0]           cfg_data,
  input  logic [AddrWidth-1:0]  byte_address,
  input  logic                  is_remove,
  input  logic [EpochWidth-1:0] current_epoch,
  input  logic [EpochWidth-1:0] collect_epoch,
  input  logic                  force_clean,
  output logic [1:0]            status,
  output logic [9:0]            entry_index,
  output logic [10:0]           occupied_count,
  output logic [9:0]            window_size
);
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = $clog2(TableEntries + 1);
  localparam int unsigned WinW = $clog2(2 * TableEntries + 1);
  localparam int unsigned TagW = AddrWidth - PageShift;
  localparam int unsigned EntW = 1 + TagW + 2 * EpochWidth;
  localparam logic [WinW-1:0] TableW = WinW'(TableEntries);
  localparam logic [WinW-1:0] DefW   = WinW'(DefaultWindow);

  typedef struct packed {
    logic                  vld;
    logic [TagW-1:0]       tag;
    logic [EpochWidth-1:0] rem;
    logic [EpochWidth-1:0] ins;
  } entry_t;

  entry_t mem [TableEntries];
  entry_t rd_q;

  logic [CntW-1:0]       idx_q, cnt_q, cnt_d;
  logic [WinW-1:0]       win_q, win_d;
  logic [CntW-1:0]       top_q;
  logic                  any_q;
  logic                  free_q, found_q;
  logic [IdxW-1:0]       free_idx_q;
  logic [10:0]           thr_q;
  logic [TagW-1:0]       tag_q;
  logic                  rem_q, sweep_q;
  logic [EpochWidth-1:0] cur_q, col_q;
  logic [1:0]            status_q;
  logic [9:0]            index_q;
  logic [CntW-1:0]       span;
  logic                  stale;
  logic                  wr_en;
  logic [IdxW-1:0]       wr_idx;
  entry_t                wr_ent;
  logic [WinW-1:0]       half;
  logic [WinW:0]         twice;

  assign span  = (win_q < TableW) ? CntW'(win_q) : CntW'(TableEntries);
  assign half  = win_q >> 1;
  assign twice = {win_q, 1'b0};
  assign stale = ((rd_q.rem < col_q) || (rd_q.rem == '0)) &&
                 ((rd_q.ins < cur_q) || (rd_q.ins == '0));

  assign stat_o.idx_last_clear = (idx_q == CntW'(TableEntries - 1));
  assign stat_o.idx_at_span    = (idx_q >= span);
  assign stat_o.need_sweep     = sweep_q;
  assign stat_o.found          = rd_q.vld && (rd_q.tag == tag_q);

  // Memory write selection and next window and count.
  always_comb begin
    wr_en  = 1'b0;
    wr_idx = idx_q[IdxW-1:0];
    wr_ent = '0;
    cnt_d  = cnt_q;
    win_d  = win_q;
    if (ctrl_i.clear_en) begin
      wr_en = 1'b1;
    end else if (ctrl_i.sweep_chk && rd_q.vld && stale) begin
      wr_en = 1'b1;
      if (cnt_q != '0) begin
        cnt_d = cnt_q - 1'b1;
      end
    end else if (ctrl_i.sweep_end) begin
      if (((!any_q) || (WinW'(top_q) < half)) && (half > DefW)) begin
        win_d = half;
      end
    end else if (ctrl_i.decide) begin
      if (found_q) begin
        wr_en  = 1'b1;
        wr_ent = rd_q;
        if (rem_q && (rd_q.rem < cur_q)) begin
          wr_ent.rem = cur_q;
        end
        if (!rem_q && (rd_q.ins < cur_q)) begin
          wr_ent.ins = cur_q;
        end
      end else if (free_q || (twice < {1'b0, TableW})) begin
        wr_en      = 1'b1;
        wr_idx     = free_q ? free_idx_q : IdxW'(win_q);
        wr_ent.vld = 1'b1;
        wr_ent.tag = tag_q;
        wr_ent.rem = rem_q ? cur_q : '0;
        wr_ent.ins = rem_q ? '0 : cur_q;
        cnt_d      = cnt_q + 1'b1;
        if (!free_q) begin
          win_d = twice[WinW-1:0];
        end
      end
    end
  end

  // Entry memory with registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_ent;
    end
    if (ctrl_i.rd_en) begin
      rd_q <= mem[idx_q[IdxW-1:0]];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      cnt_q   <= '0;
      win_q   <= DefW;
      thr_q   <= ThresholdReset;
      found_q <= 1'b0;
      free_q  <= 1'b0;
      any_q   <= 1'b0;
      top_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      win_q <= win_d;
      if (cfg_we) begin
        thr_q <= cfg_data;
      end
      if (ctrl_i.idx_zero) begin
        idx_q <= '0;
      end else if (ctrl_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (ctrl_i.load_item) begin
        found_q <= 1'b0;
        free_q  <= 1'b0;
        any_q   <= 1'b0;
        top_q   <= '0;
      end
      if (ctrl_i.sweep_chk && rd_q.vld && !stale) begin
        any_q <= 1'b1;
        top_q <= idx_q;
      end
      if (ctrl_i.search_chk) begin
        if (stat_o.found) begin
          found_q <= 1'b1;
        end else if (!rd_q.vld && !free_q) begin
          free_q <= 1'b1;
        end
      end
    end
  end

  // Item and result payload registers; the sweep decision uses the count before the item.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_item) begin
      tag_q   <= byte_address[AddrWidth-1:PageShift];
      rem_q   <= is_remove;
      cur_q   <= current_epoch;
      col_q   <= collect_epoch;
      sweep_q <= force_clean || (CntW'(cnt_q) > thr_q);
    end
    if (ctrl_i.search_chk && !stat_o.found && !rd_q.vld && !free_q) begin
      free_idx_q <= idx_q[IdxW-1:0];
    end
    if (ctrl_i.decide) begin
      if (found_q) begin
        status_q <= StHit;
        index_q  <= 10'(idx_q);
      end else if (free_q) begin
        status_q <= StFill;
        index_q  <= 10'(free_idx_q);
      end else if (twice < {1'b0, TableW}) begin
        status_q <= StGrow;
        index_q  <= 10'(win_q);
      end else begin
        status_q <= StDrop;
        index_q  <= '0;
      end
    end
  end

  assign status         = status_q;
  assign entry_index    = index_q;
  assign occupied_count = 11'(cnt_q);
  assign window_size    = 10'(win_q);
endmodule

FILE: design/eptt_checker.sv
// Port checker for the epoch page tracking table, bound to the top level.
`include "assert_macros.svh"
module eptt_checker import eptt_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [9:0]  entry_index_o,
  input logic [10:0] occupied_count_o
);
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o), "result dropped while stalled")
  `ASSERT_IMPL(a_one_item, clk_i, rst_ni, out_valid_o |-> in_stall_o, "item taken while a result waits")
  `ASSERT_IMPL(a_drop_idx, clk_i, rst_ni, out_valid_o && status_o == StDrop |-> entry_index_o == '0, "dropped item with nonzero index")
  `ASSERT_IMPL(a_fill_cnt, clk_i, rst_ni, out_valid_o && status_o != StDrop |-> occupied_count_o != '0, "empty table after a mark")
endmodule

bind epoch_page_tracking_table eptt_checker u_eptt_checker (.*);
